// ----- hw/rtl/drst_pkg.sv -----
// Package for the button release debouncer with stuck-button timeout.
// Holds field widths, reset values, patterns and register codes.
// No dependencies; every other file refers to it by scoped names.
package drst_pkg;

    // Field and state widths
    localparam int unsigned NOW_W   = 32;
    localparam int unsigned HIST_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    // Reset values and patterns
    localparam logic [HIST_W-1:0]  HISTORY_RESET     = 8'hFF;
    localparam logic [HIST_W-1:0]  RELEASE_PATTERN   = 8'h03;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [CFG_W-1:0]   STUCK_LIMIT_RESET = 16'h0700;
    localparam logic [CFG_W-1:0]   BLINK_GAP_RESET   = 16'd50;

    // Register select, taken from address bit 2
    typedef enum logic
    {
        REG_STUCK_LIMIT = 1'b0,
        REG_BLINK_GAP   = 1'b1
    } reg_sel_t;

endpackage

// ----- hw/rtl/drst_if.sv -----
// Valid/ready channel interfaces for the debouncer: poll input and result output.
// Depends on drst_pkg for field widths.
interface drst_poll_if;
    logic                      valid;
    logic                      ready;
    logic                      pin_low;
    logic [drst_pkg::NOW_W-1:0] now_ms;

    modport source (output valid, output pin_low, output now_ms, input ready);
    modport sink   (input valid, input pin_low, input now_ms, output ready);
endinterface

interface drst_result_if;
    logic valid;
    logic ready;
    logic released;
    logic stuck_error;
    logic led_level;

    modport source (output valid, output released, output stuck_error, output led_level,
                    input ready);
    modport sink   (input valid, input released, input stuck_error, input led_level,
                    output ready);
endinterface

// ----- hw/rtl/debounce_release_with_stuck_timeout_core.sv -----
// Top level of the button release debouncer with stuck-button timeout.
// Depends on drst_pkg and the channel interfaces in drst_if.sv.
//
// Each poll transfer (button level plus millisecond tick) yields exactly one result
// transfer. A poll is captured in an input register and processed when the result
// register is free; the history shift, press count, elapsed-time compare and LED toggle
// all resolve in one pass into the result register. Throughput is one poll per cycle
// while the result side takes each result. While a finished result waits, the poll
// side takes at most one more poll, into the empty input register, and then stalls
// until the result transfers. Registers (stuck_limit at 0x0, blink_gap_ms at 0x4)
// should be written only while no poll is in flight.
module debounce_release_with_stuck_timeout_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    drst_poll_if.sink                     poll,
    drst_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drst_pkg::APB_AW-1:0]   paddr,
    input  logic [drst_pkg::APB_DW-1:0]   pwdata,
    output logic [drst_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // Configuration registers
    logic [drst_pkg::CFG_W-1:0] stuck_limit_reg;
    logic [drst_pkg::CFG_W-1:0] blink_gap_reg;
    drst_pkg::reg_sel_t         reg_sel;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = drst_pkg::reg_sel_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuck_limit_reg <= drst_pkg::STUCK_LIMIT_RESET;
            blink_gap_reg   <= drst_pkg::BLINK_GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                drst_pkg::REG_STUCK_LIMIT: stuck_limit_reg <= pwdata[drst_pkg::CFG_W-1:0];
                drst_pkg::REG_BLINK_GAP:   blink_gap_reg   <= pwdata[drst_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_sel)
            drst_pkg::REG_STUCK_LIMIT:
                prdata = {{(drst_pkg::APB_DW-drst_pkg::CFG_W){1'b0}}, stuck_limit_reg};
            drst_pkg::REG_BLINK_GAP:
                prdata = {{(drst_pkg::APB_DW-drst_pkg::CFG_W){1'b0}}, blink_gap_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake: input register moves when the result register can take its item
    logic                       in_valid_reg;
    logic                       in_pin_low_reg;
    logic [drst_pkg::NOW_W-1:0] in_now_reg;
    logic                       out_valid_reg;
    logic                       out_free;
    logic                       proc_fire;

    assign out_free   = !out_valid_reg || result.ready;
    assign proc_fire  = in_valid_reg && out_free;
    assign poll.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            in_valid_reg <= poll.valid;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            in_pin_low_reg <= poll.pin_low;
            in_now_reg     <= poll.now_ms;
        end
    end

    // Debounce state
    logic [drst_pkg::HIST_W-1:0]  history_reg;
    logic [drst_pkg::HIST_W-1:0]  history_next;
    logic [drst_pkg::COUNT_W-1:0] press_count_reg;
    logic [drst_pkg::COUNT_W-1:0] press_count_next;
    logic [drst_pkg::NOW_W-1:0]   mark_reg;
    logic [drst_pkg::NOW_W-1:0]   mark_next;
    logic                         led_state_reg;
    logic                         led_state_next;
    logic                         stuck;
    logic [drst_pkg::NOW_W-1:0]   elapsed;
    logic                         gap_passed;

    assign elapsed    = in_now_reg - mark_reg;
    assign gap_passed = elapsed > {{(drst_pkg::NOW_W-drst_pkg::CFG_W){1'b0}}, blink_gap_reg};

    // One-pass update for the poll in the input register
    always_comb
    begin
        history_next     = history_reg;
        press_count_next = press_count_reg;
        mark_next        = mark_reg;
        led_state_next   = led_state_reg;
        stuck            = 1'b0;
        if (in_pin_low_reg)
        begin
            if (press_count_reg != drst_pkg::COUNT_MAX)
            begin
                press_count_next = press_count_reg + 1'b1;
            end
            if (press_count_reg <= stuck_limit_reg)
            begin
                history_next = {history_reg[drst_pkg::HIST_W-2:0], 1'b0};
            end
            else
            begin
                stuck        = 1'b1;
                history_next = drst_pkg::HISTORY_RESET;
                if (gap_passed)
                begin
                    led_state_next = !led_state_reg;
                    mark_next      = in_now_reg;
                end
            end
        end
        else
        begin
            history_next     = {history_reg[drst_pkg::HIST_W-2:0], 1'b1};
            press_count_next = '0;
            mark_next        = in_now_reg;
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg        <= drst_pkg::HISTORY_RESET;
            press_count_reg    <= '0;
            mark_reg           <= '0;
            led_state_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            result.released    <= 1'b0;
            result.stuck_error <= 1'b0;
            result.led_level   <= 1'b0;
        end
        else
        begin
            if (proc_fire)
            begin
                history_reg        <= history_next;
                press_count_reg    <= press_count_next;
                mark_reg           <= mark_next;
                led_state_reg      <= led_state_next;
                result.released    <= (history_next == drst_pkg::RELEASE_PATTERN);
                result.stuck_error <= stuck;
                result.led_level   <= led_state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    assign result.valid = out_valid_reg;

    // A stuck poll forces the history to all released, so it can never report a release
    a_stuck_not_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result.released && result.stuck_error))
        else $error("stuck poll reported a release");

    // A released poll clears the press count and marks the time
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && !in_pin_low_reg) |=> (press_count_reg == '0 && mark_reg == $past(in_now_reg)))
        else $error("released poll did not clear count and mark");

    // The LED changes only on a processed stuck poll
    a_led_only_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        (led_state_reg != $past(led_state_reg)) |-> $past(proc_fire && stuck))
        else $error("LED toggled outside the stuck branch");

    // The result register does not take a new item while a result waits unaccepted
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(led_state_reg)))
        else $error("pending result overwritten");

endmodule
